>>> design/elevator_dispatch_controller_macros.svh
// assertion helpers used by the dispatcher design file
`ifndef ELEVATOR_DISPATCH_CONTROLLER_MACROS_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define EDC_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("edc assertion failed");

// next-cycle implication, checked out of reset
`define EDC_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("edc assertion failed");

`endif

>>> design/edc_pkg.sv
package edc_pkg;
  localparam int unsigned FloorsDef    = 5;
  localparam int unsigned WaitSlotsDef = 16;
  localparam int unsigned CarSlotsDef  = 8;
  localparam int unsigned StopDepth    = 16;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] CFG_MAX_LOAD     = 2'd0;
  localparam logic [1:0] CFG_RIDER_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDLE_TICKS   = 2'd2;

  localparam logic [11:0] MaxLoadRst     = 12'd600;
  localparam logic [7:0]  RiderWeightRst = 8'd70;
  localparam logic [7:0]  IdleTicksRst   = 8'd5;
endpackage

>>> design/elevator_dispatch_controller.sv
// Single-car elevator dispatcher. Each input word is a timer tick (action 0) or a call press
// (action 1) and returns exactly one result word. Waiting riders live in a synchronous RAM of
// FLOORS*WAIT_SLOTS entries, one row per floor, read in S_LDRD and checked in S_LDEV one rider at
// a time, a rider who stays being written back. A call passes S_CALL, then S_DONE; a tick with
// stops pending moves the car, runs S_UNLOAD over the riders in the car, the load pass over the
// riders waiting at the floor, S_POP and S_HEAD; an idle tick searches the floors in S_SEARCH
// and decides in S_SDEC. One word is in work at a time; a finished result waits in the output
// register while the next word is taken.
`include "elevator_dispatch_controller_macros.svh"

module elevator_dispatch_controller import edc_pkg::*; #(
  parameter int unsigned FLOORS     = FloorsDef,
  parameter int unsigned WAIT_SLOTS = WaitSlotsDef,
  parameter int unsigned CAR_SLOTS  = CarSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [3:0]  from_floor_i,
  input  logic [3:0]  to_floor_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  car_floor_o,
  output logic [1:0]  travel_o,
  output logic [4:0]  riders_o,
  output logic [11:0] car_load_o,
  output logic [4:0]  exited_o,
  output logic [4:0]  boarded_o,
  output logic [4:0]  stops_pending_o,
  output logic        call_rejected_o,
  output logic        car_idle_o
);
  localparam int unsigned AW  = $clog2(FLOORS * WAIT_SLOTS);
  localparam int unsigned FW  = $clog2(FLOORS);
  localparam int unsigned SFW = $clog2(FLOORS + 1);
  localparam int unsigned WCW = $clog2(WAIT_SLOTS + 1);
  localparam int unsigned RCW = $clog2(CAR_SLOTS + 1);
  localparam int unsigned RIW = (CAR_SLOTS > 1) ? $clog2(CAR_SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_UNLOAD, S_LDRD, S_LDEV, S_POP, S_HEAD, S_SEARCH, S_SDEC, S_CALL, S_DONE
  } state_e;

  state_e         state_q;
  logic           act_q;
  logic [3:0]     from_q, to_q;
  logic [3:0]     floor_q;
  logic [1:0]     head_q;
  logic [3:0]     rdest_q [CAR_SLOTS];
  logic [RCW-1:0] rc_q;
  logic [WCW-1:0] wcnt_q [FLOORS];
  logic [3:0]     stop_q [StopDepth];
  logic [4:0]     sc_q;
  logic           imark_q;
  logic [7:0]     iel_q;
  logic [3:0]     target_q;
  logic [RCW-1:0] ui_q, ukeep_q;
  logic [4:0]     left_q, got_q;
  logic [WCW-1:0] li_q, lkeep_q, ln_q;
  logic           refused_q, pop_q;
  logic [SFW-1:0] sf_q;
  logic [3:0]     best_q;
  logic [4:0]     bestd_q;
  logic           found_q, rej_q;
  logic [11:0]    ml_q;
  logic [7:0]     rw_q, irt_q;
  logic           out_valid_q;
  logic [3:0]     o_floor_q;
  logic [1:0]     o_travel_q;
  logic [4:0]     o_riders_q, o_exited_q, o_boarded_q, o_stops_q;
  logic [11:0]    o_load_q;
  logic           o_rej_q, o_idle_q;

  function automatic logic [1:0] toward(input logic [3:0] f, input logic [3:0] cur);
    if (f > cur) return DIR_UP;
    else if (f < cur) return DIR_DOWN;
    else return DIR_IDLE;
  endfunction

  // shared count read port
  logic [FW-1:0]  wc_idx;
  logic [WCW-1:0] wc_rd;
  always_comb begin
    unique case (state_q)
      S_CALL:   wc_idx = from_q[FW-1:0];
      S_SEARCH: wc_idx = sf_q[FW-1:0];
      default:  wc_idx = floor_q[FW-1:0];
    endcase
  end
  assign wc_rd = wcnt_q[wc_idx];

  // waiting ram
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, floor_base;
  logic [3:0]    mem_wdata, mem_rdata;
  logic          call_ok;
  logic [12:0]    need_w;
  logic          fits, way;
  logic [7:0]    iel_inc;

  assign floor_base = AW'(floor_q) * AW'(WAIT_SLOTS);
  assign call_ok = ({1'b0, from_q} < 5'(FLOORS)) && ({1'b0, to_q} < 5'(FLOORS)) &&
                   (from_q != to_q) && (wc_rd < WCW'(WAIT_SLOTS));
  assign need_w = 13'(rc_q) * 13'(rw_q) + 13'(rw_q);
  assign fits = (rc_q < RCW'(CAR_SLOTS)) && (need_w <= 13'(ml_q));
  assign way = (head_q == DIR_IDLE) || (head_q == DIR_UP && mem_rdata > floor_q) ||
               (head_q == DIR_DOWN && mem_rdata < floor_q);
  assign iel_inc = (iel_q == 8'hFF) ? iel_q : iel_q + 8'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = floor_base + AW'(lkeep_q);
    mem_wdata = mem_rdata;
    mem_raddr = floor_base + AW'(li_q);
    if (state_q == S_CALL) begin
      mem_we    = call_ok;
      mem_waddr = AW'(from_q) * AW'(WAIT_SLOTS) + AW'(wc_rd);
      mem_wdata = to_q;
    end else if (state_q == S_LDEV) begin
      mem_we = !fits || !way;
    end
  end

  edc_wait_ram #(.Depth(FLOORS * WAIT_SLOTS), .AddrW(AW)) u_wait_ram (
    .clk_i, .rst_ni,
    .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  // one stop-list append per cycle at most
  logic       add_req, add_hit;
  logic [3:0] add_fl;
  always_comb begin
    add_req = 1'b0;
    add_fl  = floor_q;
    unique case (state_q)
      S_CALL: begin
        add_req = call_ok;
        add_fl  = from_q;
      end
      S_LDEV: begin
        add_req = fits && way;
        add_fl  = mem_rdata;
      end
      S_HEAD: add_req = refused_q && pop_q;
      S_SDEC: begin
        if (found_q) begin
          add_req = 1'b1;
          add_fl  = best_q;
        end else if (imark_q && iel_inc >= irt_q && floor_q != 4'd0) begin
          add_req = 1'b1;
          add_fl  = 4'd0;
        end
      end
      default: add_req = 1'b0;
    endcase
    add_hit = 1'b0;
    for (int i = 0; i < StopDepth; i++) begin
      if (5'(i) < sc_q && stop_q[i] == add_fl) add_hit = 1'b1;
    end
  end

  logic [4:0] sdist;
  assign sdist = (5'(sf_q) > {1'b0, floor_q}) ? 5'(sf_q) - {1'b0, floor_q}
                                              : {1'b0, floor_q} - 5'(sf_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      floor_q     <= 4'd0;
      head_q      <= DIR_IDLE;
      rc_q        <= '0;
      sc_q        <= 5'd0;
      imark_q     <= 1'b0;
      iel_q       <= 8'd0;
      out_valid_q <= 1'b0;
      ml_q        <= MaxLoadRst;
      rw_q        <= RiderWeightRst;
      irt_q       <= IdleTicksRst;
      for (int f = 0; f < FLOORS; f++) wcnt_q[f] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAX_LOAD:     ml_q  <= cfg_data_i;
          CFG_RIDER_WEIGHT: rw_q  <= cfg_data_i[7:0];
          CFG_IDLE_TICKS:   irt_q <= cfg_data_i[7:0];
          default:          ;
        endcase
      end
      // the done state loads the next word itself when the output frees up
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      if (add_req && !add_hit && sc_q < 5'(StopDepth)) begin
        stop_q[sc_q[3:0]] <= add_fl;
        sc_q <= sc_q + 5'd1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q  <= action_i;
            from_q <= from_floor_i;
            to_q   <= to_floor_i;
            rej_q  <= 1'b0;
            left_q <= 5'd0;
            got_q  <= 5'd0;
            state_q <= action_i ? S_CALL : S_TICK;
          end
        end
        S_CALL: begin
          rej_q <= !call_ok;
          if (call_ok) wcnt_q[from_q[FW-1:0]] <= wc_rd + WCW'(1);
          state_q <= S_DONE;
        end
        S_TICK: begin
          if (sc_q != 5'd0) begin
            imark_q  <= 1'b0;
            target_q <= stop_q[0];
            head_q   <= toward(stop_q[0], floor_q);
            if (toward(stop_q[0], floor_q) == DIR_UP) floor_q <= floor_q + 4'd1;
            else if (toward(stop_q[0], floor_q) == DIR_DOWN) floor_q <= floor_q - 4'd1;
            ui_q    <= '0;
            ukeep_q <= '0;
            state_q <= S_UNLOAD;
          end else if (rc_q == '0) begin
            sf_q    <= '0;
            bestd_q <= 5'(FLOORS + 1);
            best_q  <= 4'd0;
            found_q <= 1'b0;
            state_q <= S_SEARCH;
          end else begin
            imark_q <= 1'b0;
            head_q  <= (rdest_q[0] > floor_q) ? DIR_UP : DIR_DOWN;
            state_q <= S_DONE;
          end
        end
        S_UNLOAD: begin
          if (ui_q == rc_q) begin
            rc_q      <= ukeep_q;
            ln_q      <= wc_rd;
            li_q      <= '0;
            lkeep_q   <= '0;
            refused_q <= 1'b0;
            state_q   <= S_LDRD;
          end else begin
            if (rdest_q[ui_q[RIW-1:0]] == floor_q) begin
              left_q <= left_q + 5'd1;
            end else begin
              rdest_q[ukeep_q[RIW-1:0]] <= rdest_q[ui_q[RIW-1:0]];
              ukeep_q <= ukeep_q + RCW'(1);
            end
            ui_q <= ui_q + RCW'(1);
          end
        end
        S_LDRD: begin
          if (li_q == ln_q) begin
            wcnt_q[floor_q[FW-1:0]] <= lkeep_q;
            state_q <= S_POP;
          end else begin
            state_q <= S_LDEV;
          end
        end
        S_LDEV: begin
          if (!fits) begin
            refused_q <= 1'b1;
            lkeep_q   <= lkeep_q + WCW'(1);
          end else if (way) begin
            rdest_q[rc_q[RIW-1:0]] <= mem_rdata;
            rc_q  <= rc_q + RCW'(1);
            got_q <= got_q + 5'd1;
          end else begin
            lkeep_q <= lkeep_q + WCW'(1);
          end
          li_q    <= li_q + WCW'(1);
          state_q <= S_LDRD;
        end
        S_POP: begin
          pop_q <= (target_q == floor_q);
          if (target_q == floor_q) begin
            for (int i = 0; i < StopDepth - 1; i++) stop_q[i] <= stop_q[i+1];
            sc_q <= sc_q - 5'd1;
          end
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          // a re-added floor on an empty list is the car's own floor, so idle anyway
          head_q  <= (sc_q != 5'd0) ? toward(stop_q[0], floor_q) : DIR_IDLE;
          state_q <= S_DONE;
        end
        S_SEARCH: begin
          if (sf_q == SFW'(FLOORS)) begin
            state_q <= S_SDEC;
          end else begin
            if (wc_rd != '0 && sdist < bestd_q) begin
              bestd_q <= sdist;
              best_q  <= 4'(sf_q);
              found_q <= 1'b1;
            end
            sf_q <= sf_q + SFW'(1);
          end
        end
        S_SDEC: begin
          if (found_q) begin
            head_q  <= (best_q > floor_q) ? DIR_UP : DIR_DOWN;
            imark_q <= 1'b0;
          end else if (!imark_q) begin
            imark_q <= 1'b1;
            iel_q   <= 8'd0;
          end else begin
            iel_q <= iel_inc;
            if (iel_inc >= irt_q && floor_q != 4'd0) head_q <= DIR_DOWN;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_floor_q   <= floor_q;
            o_travel_q  <= head_q;
            o_riders_q  <= 5'(rc_q);
            o_load_q    <= 12'(13'(rc_q) * 13'(rw_q));
            o_exited_q  <= act_q ? 5'd0 : left_q;
            o_boarded_q <= act_q ? 5'd0 : got_q;
            o_stops_q   <= sc_q;
            o_rej_q     <= act_q & rej_q;
            o_idle_q    <= imark_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign car_floor_o     = o_floor_q;
  assign travel_o        = o_travel_q;
  assign riders_o        = o_riders_q;
  assign car_load_o      = o_load_q;
  assign exited_o        = o_exited_q;
  assign boarded_o       = o_boarded_q;
  assign stops_pending_o = o_stops_q;
  assign call_rejected_o = o_rej_q;
  assign car_idle_o      = o_idle_q;

  `EDC_ASSERT_NOW(a_stop_bound, 1'b1, sc_q <= 5'(StopDepth))
  `EDC_ASSERT_NOW(a_car_bound, 1'b1, rc_q <= RCW'(CAR_SLOTS))
  `EDC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `EDC_ASSERT_NOW(a_floor_range, 1'b1, {1'b0, floor_q} < 5'(FLOORS))
endmodule

>>> design/edc_wait_ram.sv
module edc_wait_ram #(
  parameter int unsigned Depth = 80,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [3:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [3:0]       rdata_o
);
  logic [3:0] mem_q [Depth];
  logic [3:0] rdata_q;
  logic       rst_seen_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // marks the first cycle out of reset; keeps reset in use for this port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q <= 1'b0;
    end else begin
      rst_seen_q <= 1'b1;
    end
  end

  assign rdata_o = rst_seen_q ? rdata_q : 4'd0;
endmodule
